// File: rtl/core/irdl_pkg.sv
`timescale 1ns / 1ps
// shared constants for the ir distance linearizer and median filter
// no dependencies; used by every module under rtl/core
package irdl_pkg;

	localparam int CODE_W         = 8;
	localparam int CM_W           = 7;
	localparam int HUND_W         = 13;
	localparam int HUND_CALC_W    = 14;
	localparam int WINDOW_LEN_DEF = 7;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;

	// segment breakpoints: a code above the limit belongs to the segment above
	localparam logic [CODE_W-1:0] BRK_FAR  = 8'd132;
	localparam logic [CODE_W-1:0] BRK_S1   = 8'd91;
	localparam logic [CODE_W-1:0] BRK_S2   = 8'd70;
	localparam logic [CODE_W-1:0] BRK_S3   = 8'd49;
	localparam logic [CODE_W-1:0] BRK_S4   = 8'd37;
	localparam logic [CODE_W-1:0] BRK_NEAR = 8'd22;

	// offsets and slopes in hundredths of a centimetre
	localparam logic [HUND_CALC_W-1:0] OFS_0 = 14'd2610;
	localparam logic [HUND_CALC_W-1:0] OFS_1 = 14'd3667;
	localparam logic [HUND_CALC_W-1:0] OFS_2 = 14'd5333;
	localparam logic [HUND_CALC_W-1:0] OFS_3 = 14'd7083;
	localparam logic [HUND_CALC_W-1:0] OFS_4 = 14'd11400;
	localparam logic [CODE_W-1:0] SLP_0 = 8'd12;
	localparam logic [CODE_W-1:0] SLP_1 = 8'd24;
	localparam logic [CODE_W-1:0] SLP_2 = 8'd48;
	localparam logic [CODE_W-1:0] SLP_3 = 8'd83;
	localparam logic [CODE_W-1:0] SLP_4 = 8'd200;

	// saturated ends expressed as hundredths so they share the divide path
	localparam logic [HUND_W-1:0] HUND_FAR  = 13'd1000;
	localparam logic [HUND_W-1:0] HUND_NEAR = 13'd7500;

	// floor(h / 100) = (h * 5243) >> 19, exact for any 13-bit h
	localparam int                RECIP_W     = 13;
	localparam logic [RECIP_W-1:0] RECIP_100  = 13'd5243;
	localparam int                RECIP_SHIFT = 19;

	localparam logic [CM_W-1:0] CM_MIN = 7'd10;
	localparam logic [CM_W-1:0] CM_MAX = 7'd75;

endpackage

// File: rtl/core/irdl_segment.sv
`timescale 1ns / 1ps
// piecewise-linear segment select: adc code to distance in hundredths of a cm
// depends on irdl_pkg
module irdl_segment (
	input  logic [irdl_pkg::CODE_W-1:0] code,
	output logic [irdl_pkg::HUND_W-1:0] hund
);

	logic [irdl_pkg::HUND_CALC_W-1:0] code_x;
	logic [irdl_pkg::HUND_CALC_W-1:0] ofs;
	logic [irdl_pkg::HUND_CALC_W-1:0] slp;
	logic [irdl_pkg::HUND_CALC_W-1:0] diff;
	logic                             sat_far;
	logic                             sat_near;

	assign code_x = irdl_pkg::HUND_CALC_W'(code);

	always_comb begin
		sat_far  = 1'b0;
		sat_near = 1'b0;
		ofs      = irdl_pkg::OFS_0;
		slp      = irdl_pkg::HUND_CALC_W'(irdl_pkg::SLP_0);
		priority if (code > irdl_pkg::BRK_FAR) begin
			sat_far = 1'b1;
		end else if (code > irdl_pkg::BRK_S1) begin
			ofs = irdl_pkg::OFS_0;
			slp = irdl_pkg::HUND_CALC_W'(irdl_pkg::SLP_0);
		end else if (code > irdl_pkg::BRK_S2) begin
			ofs = irdl_pkg::OFS_1;
			slp = irdl_pkg::HUND_CALC_W'(irdl_pkg::SLP_1);
		end else if (code > irdl_pkg::BRK_S3) begin
			ofs = irdl_pkg::OFS_2;
			slp = irdl_pkg::HUND_CALC_W'(irdl_pkg::SLP_2);
		end else if (code > irdl_pkg::BRK_S4) begin
			ofs = irdl_pkg::OFS_3;
			slp = irdl_pkg::HUND_CALC_W'(irdl_pkg::SLP_3);
		end else if (code > irdl_pkg::BRK_NEAR) begin
			ofs = irdl_pkg::OFS_4;
			slp = irdl_pkg::HUND_CALC_W'(irdl_pkg::SLP_4);
		end else begin
			sat_near = 1'b1;
		end
	end

	// constant slopes keep this a shift-and-add, never negative inside a segment
	assign diff = ofs - irdl_pkg::HUND_CALC_W'(slp * code_x);

	always_comb begin
		priority if (sat_far) begin
			hund = irdl_pkg::HUND_FAR;
		end else if (sat_near) begin
			hund = irdl_pkg::HUND_NEAR;
		end else begin
			hund = diff[irdl_pkg::HUND_W-1:0];
		end
	end

endmodule

// File: rtl/core/irdl_window.sv
`timescale 1ns / 1ps
// circular window of recent distances with a rank-select median
// depends on irdl_pkg
module irdl_window #(
	parameter int WINDOW_LEN = irdl_pkg::WINDOW_LEN_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [irdl_pkg::CM_W-1:0] wr_cm,
	output logic [irdl_pkg::CM_W-1:0] median_cm
);

	localparam int SLOT_W = $clog2(WINDOW_LEN);
	localparam int RANK_W = $clog2(WINDOW_LEN);
	localparam int MID    = WINDOW_LEN / 2;

	logic [irdl_pkg::CM_W-1:0] win_q [WINDOW_LEN];
	logic [SLOT_W-1:0]         slot_q;
	logic [RANK_W-1:0]         rank [WINDOW_LEN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				win_q[i] <= '0;
			end
			slot_q <= '0;
		end else if (wr_en) begin
			win_q[slot_q] <= wr_cm;
			if (slot_q == SLOT_W'(WINDOW_LEN - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + SLOT_W'(1);
			end
		end
	end

	// equal values are ordered by position, so every entry gets a distinct rank
	always_comb begin
		for (int i = 0; i < WINDOW_LEN; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WINDOW_LEN; j++) begin
				if ((j < i && win_q[j] <= win_q[i]) || (j > i && win_q[j] < win_q[i])) begin
					rank[i] = rank[i] + RANK_W'(1);
				end
			end
		end
	end

	always_comb begin
		median_cm = '0;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			if (rank[i] == RANK_W'(MID)) begin
				median_cm = median_cm | win_q[i];
			end
		end
	end

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(WINDOW_LEN - 1))
		else $error("window slot out of range");

endmodule

// File: rtl/core/ir_distance_linearize_median.sv
`timescale 1ns / 1ps
// top level: ir range code to centimetres plus a sliding median of recent distances
// depends on irdl_pkg, irdl_segment, irdl_window
//
// one 8-bit adc code enters per word on the s_axis channel; every accepted word
// gives exactly one result word on the m_axis channel, in order
// result word: raw distance (10..75 cm) and the median of the last WINDOW_LEN
// distances including this one; the window holds zeros after reset
// pipeline: input register, segment/offset stage, divide-by-100 and window
// write stage, median output register
// throughput: one word per cycle while m_axis_tready is high, set by the single-pass pipeline with no loops
// when m_axis_tready is low the output register holds its word and the
// stages behind it keep filling, so up to three more words are taken before
// s_axis_tready drops
// reset (arst_n low) empties every stage, clears the window to zero and puts
// the write slot back at the first entry
module ir_distance_linearize_median #(
	parameter int WINDOW_LEN = irdl_pkg::WINDOW_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [irdl_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] adc_code
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [irdl_pkg::OUT_DATA_W-1:0] m_axis_tdata   // [6:0] raw_cm, [13:7] median_cm
);

	localparam int PROD_W = irdl_pkg::HUND_W + irdl_pkg::RECIP_W;

	logic                        valid_s1, valid_s2, valid_s3, valid_s4;
	logic                        ready_s1, ready_s2, ready_s3, ready_s4;
	logic [irdl_pkg::CODE_W-1:0] code_s1;
	logic [irdl_pkg::HUND_W-1:0] hund_s2;
	logic [irdl_pkg::CM_W-1:0]   raw_s3;
	logic [irdl_pkg::CM_W-1:0]   raw_s4;
	logic [irdl_pkg::CM_W-1:0]   median_s4;
	logic [irdl_pkg::HUND_W-1:0] hund;
	logic [PROD_W-1:0]           prod;
	logic [irdl_pkg::CM_W-1:0]   cm_div;
	logic [irdl_pkg::CM_W-1:0]   cm_clamped;
	logic [irdl_pkg::CM_W-1:0]   median_cm;
	logic                        win_wr;

	// each stage may load when it is empty or its word moves on
	assign ready_s4 = !valid_s4 || m_axis_tready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;

	assign s_axis_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_axis_tvalid) begin
			code_s1 <= s_axis_tdata[irdl_pkg::CODE_W-1:0];
		end
		if (ready_s2 && valid_s1) begin
			hund_s2 <= hund;
		end
		if (ready_s3 && valid_s2) begin
			raw_s3 <= cm_clamped;
		end
		if (ready_s4 && valid_s3) begin
			raw_s4    <= raw_s3;
			median_s4 <= median_cm;
		end
	end

	irdl_segment u_segment (
		.code (code_s1),
		.hund (hund)
	);

	// divide by 100 through the reciprocal, then guard the range
	assign prod   = PROD_W'(hund_s2) * PROD_W'(irdl_pkg::RECIP_100);
	assign cm_div = prod[irdl_pkg::RECIP_SHIFT +: irdl_pkg::CM_W];

	always_comb begin
		priority if (cm_div < irdl_pkg::CM_MIN) begin
			cm_clamped = irdl_pkg::CM_MIN;
		end else if (cm_div > irdl_pkg::CM_MAX) begin
			cm_clamped = irdl_pkg::CM_MAX;
		end else begin
			cm_clamped = cm_div;
		end
	end

	// the window takes a distance as its word enters stage 3, so the median
	// read as that word leaves stage 3 covers it and nothing newer
	assign win_wr = ready_s3 && valid_s2;

	irdl_window #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (win_wr),
		.wr_cm     (cm_clamped),
		.median_cm (median_cm)
	);

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = {{(irdl_pkg::OUT_DATA_W - 2 * irdl_pkg::CM_W){1'b0}}, median_s4, raw_s4};

	a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s4 |-> s_axis_tready)
		else $error("input stalled with an empty output stage");

	a_raw_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (raw_s4 >= irdl_pkg::CM_MIN && raw_s4 <= irdl_pkg::CM_MAX))
		else $error("raw distance outside clamp range");

	a_median_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> median_s4 <= irdl_pkg::CM_MAX)
		else $error("median above largest distance");

	a_full_pipe_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && valid_s4 && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken with every stage full and output stalled");

endmodule
